/* sv/four_neighbour_mean_filter_top_assert.svh */
// assertion macros shared by the filter modules
`ifndef FOUR_NEIGHBOUR_MEAN_FILTER_TOP_ASSERT_SVH
`define FOUR_NEIGHBOUR_MEAN_FILTER_TOP_ASSERT_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define FNMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define FNMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fnmf_pkg.sv */
package fnmf_pkg;

  // default frame limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MEAN_W    = 24;
  localparam int unsigned OUT_ROW_W = 10;
  localparam int unsigned OUT_COL_W = 10;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 48;

  // neighbour sums: up to four samples
  localparam int unsigned SUM_W   = SAMPLE_W + 2;
  localparam int unsigned Q8_SHIFT = 8;
  localparam int unsigned MAG_W   = SUM_W + Q8_SHIFT - 1;

  // rounded divide by three: round(256*a/3) = 85*a + floor((a+1)/3)
  localparam int unsigned RECIP3_W     = 16;
  localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;
  localparam int unsigned THIRD_OF_255 = 85;

  // configuration port
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     DIM_MIN   = 11'd2;
  localparam logic [CFG_W-1:0]     DIM_RESET = 11'd2;

  // results one word can release, in output order
  localparam int unsigned RES_N      = 3;
  localparam int unsigned RES_UP     = 0;
  localparam int unsigned RES_LEFT   = 1;
  localparam int unsigned RES_CORNER = 2;

  typedef enum logic [1:0] {
    DIV2,
    DIV3,
    DIV4
  } div_e;

  // everything one accepted word releases
  typedef struct packed {
    logic [RES_N-1:0]            mask;
    logic signed [SUM_W-1:0]     sum_up;
    div_e                        div_up;
    logic signed [SUM_W-1:0]     sum_left;
    div_e                        div_left;
    logic signed [SUM_W-1:0]     sum_corner;
    logic [OUT_ROW_W-1:0]        row_up;
    logic [OUT_ROW_W-1:0]        row_cur;
    logic [OUT_COL_W-1:0]        col_cur;
    logic [OUT_COL_W-1:0]        col_left;
  } job_t;

endpackage

/* sv/fnmf_ram.sv */
module fnmf_ram #(
  parameter int unsigned WIDTH = fnmf_pkg::SAMPLE_W,
  parameter int unsigned DEPTH = fnmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read returning the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/fnmf_delay.sv */
module fnmf_delay #(
  parameter int unsigned DEPTH = fnmf_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  logic                                push_i,
  input  logic [$clog2(DEPTH)-1:0]            last_i,
  input  logic signed [fnmf_pkg::SAMPLE_W-1:0] din_i,
  output logic signed [fnmf_pkg::SAMPLE_W-1:0] dout_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [AW-1:0]                        ptr_q, ptr_d;
  logic                                 fwd_q;
  logic [fnmf_pkg::SAMPLE_W-1:0]        fwd_data_q;
  logic [fnmf_pkg::SAMPLE_W-1:0]        rdata;

  // circular pointer over last_i+1 entries
  always_comb begin
    ptr_d = ptr_q;
    if (restart_i) begin
      ptr_d = '0;
    end else if (push_i) begin
      ptr_d = (ptr_q == last_i) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      fwd_q <= push_i && (ptr_d == ptr_q);
    end
  end

  // bypass for a one-entry ring, where the read hits the word just written
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fwd_data_q <= din_i;
    end
  end

  fnmf_ram #(
    .WIDTH (fnmf_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (ptr_q),
    .wdata_i (din_i),
    .raddr_i (ptr_d),
    .rdata_o (rdata)
  );

  assign dout_o = fwd_q ? fwd_data_q : rdata;

endmodule

/* sv/fnmf_cfg.sv */
module fnmf_cfg #(
  parameter int unsigned MAX_WIDTH  = fnmf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = fnmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fnmf_pkg::PADDR_W-1:0]        paddr,
  input  logic [fnmf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [fnmf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [$clog2(MAX_WIDTH)-1:0]        w_last_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        ptr_last_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]       h_last_o,
  output logic                                restart_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [fnmf_pkg::REG_IDX_W-1:0] idx;
  logic [fnmf_pkg::CFG_W-1:0]     wval;
  logic                           wr;
  logic [fnmf_pkg::CFG_W-1:0]     width_q, width_d;
  logic [fnmf_pkg::CFG_W-1:0]     height_q, height_d;
  logic [CW-1:0]                  w_last_q, w_last_d;
  logic [CW-1:0]                  ptr_last_q, ptr_last_d;
  logic [RW-1:0]                  h_last_q, h_last_d;
  logic [CW-1:0]                  w_last_new;
  logic [RW-1:0]                  h_last_new;

  assign pready = 1'b1;
  assign idx    = paddr[fnmf_pkg::PADDR_W-1:2];
  assign wval   = pwdata[fnmf_pkg::CFG_W-1:0];
  assign wr     = psel && penable && pwrite;

  // clamp the written value into 2..max and keep it as last index
  always_comb begin
    if (wval < fnmf_pkg::DIM_MIN) begin
      w_last_new = CW'(1);
    end else if (32'(wval) > MAX_WIDTH) begin
      w_last_new = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_new = CW'(wval - 1'b1);
    end
    if (wval < fnmf_pkg::DIM_MIN) begin
      h_last_new = RW'(1);
    end else if (32'(wval) > MAX_HEIGHT) begin
      h_last_new = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last_new = RW'(wval - 1'b1);
    end
  end

  // register writes
  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    w_last_d   = w_last_q;
    ptr_last_d = ptr_last_q;
    h_last_d   = h_last_q;
    if (wr) begin
      case (idx)
        fnmf_pkg::REG_FRAME_WIDTH: begin
          width_d    = wval;
          w_last_d   = w_last_new;
          ptr_last_d = w_last_new - 1'b1;
        end
        fnmf_pkg::REG_FRAME_HEIGHT: begin
          height_d = wval;
          h_last_d = h_last_new;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= fnmf_pkg::DIM_RESET;
      height_q   <= fnmf_pkg::DIM_RESET;
      w_last_q   <= CW'(1);
      ptr_last_q <= '0;
      h_last_q   <= RW'(1);
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      w_last_q   <= w_last_d;
      ptr_last_q <= ptr_last_d;
      h_last_q   <= h_last_d;
    end
  end

  // read back the raw values
  always_comb begin
    case (idx)
      fnmf_pkg::REG_FRAME_WIDTH:  prdata = fnmf_pkg::APB_DATA_W'(width_q);
      fnmf_pkg::REG_FRAME_HEIGHT: prdata = fnmf_pkg::APB_DATA_W'(height_q);
      default:                    prdata = '0;
    endcase
  end

  assign w_last_o   = w_last_q;
  assign ptr_last_o = ptr_last_q;
  assign h_last_o   = h_last_q;
  assign restart_o  = wr;

endmodule

/* sv/fnmf_out.sv */
`include "four_neighbour_mean_filter_top_assert.svh"

module fnmf_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               job_valid_i,
  input  fnmf_pkg::job_t                     job_i,
  output logic                               job_ready_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [23:0] neighbour_mean, [33:24] out_row, [43:34] out_col, [47:44] zero
  output logic [fnmf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // frame_done
  output logic                               m_axis_tlast
);

  localparam int unsigned SUM_W   = fnmf_pkg::SUM_W;
  localparam int unsigned MAG_W   = fnmf_pkg::MAG_W;
  localparam int unsigned PROD_W  = SUM_W + fnmf_pkg::RECIP3_W;
  localparam int unsigned PAD_W   = fnmf_pkg::M_TDATA_W - fnmf_pkg::MEAN_W
                                    - fnmf_pkg::OUT_ROW_W - fnmf_pkg::OUT_COL_W;

  fnmf_pkg::job_t                     job_q;
  logic [fnmf_pkg::RES_N-1:0]         mask_q, mask_d;
  logic [fnmf_pkg::RES_N-1:0]         sel_bit;
  logic [fnmf_pkg::RES_N-1:0]         mask_left;
  logic                               pending;
  logic                               load;
  logic                               accept_job;
  logic signed [SUM_W-1:0]            sel_sum;
  fnmf_pkg::div_e                     sel_div;
  logic [fnmf_pkg::OUT_ROW_W-1:0]     sel_row;
  logic [fnmf_pkg::OUT_COL_W-1:0]     sel_col;
  logic                               sel_done;
  logic                               neg;
  logic [SUM_W-1:0]                   mag;
  logic [SUM_W-1:0]                   mag_p1;
  logic [PROD_W-1:0]                  prod;
  logic [MAG_W-1:0]                   q3;
  logic [MAG_W-1:0]                   mag_q8;
  logic [MAG_W-1:0]                   mean_full;
  logic                               tvalid_q;
  logic [fnmf_pkg::M_TDATA_W-1:0]     tdata_q;
  logic                               tlast_q;

  // pick the next result of the held word: up, then left, then corner
  always_comb begin
    sel_bit                       = '0;
    sel_sum                       = job_q.sum_corner;
    sel_div                       = fnmf_pkg::DIV2;
    sel_row                       = job_q.row_cur;
    sel_col                       = job_q.col_cur;
    sel_done                      = 1'b1;
    if (mask_q[fnmf_pkg::RES_UP]) begin
      sel_bit[fnmf_pkg::RES_UP]   = 1'b1;
      sel_sum                     = job_q.sum_up;
      sel_div                     = job_q.div_up;
      sel_row                     = job_q.row_up;
      sel_done                    = 1'b0;
    end else if (mask_q[fnmf_pkg::RES_LEFT]) begin
      sel_bit[fnmf_pkg::RES_LEFT] = 1'b1;
      sel_sum                     = job_q.sum_left;
      sel_div                     = job_q.div_left;
      sel_col                     = job_q.col_left;
      sel_done                    = 1'b0;
    end else begin
      sel_bit[fnmf_pkg::RES_CORNER] = 1'b1;
    end
  end

  // rounded mean in q.8, symmetric around zero
  always_comb begin
    neg    = sel_sum[SUM_W-1];
    mag    = neg ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    mag_p1 = mag + 1'b1;
    prod   = PROD_W'(mag_p1) * PROD_W'(fnmf_pkg::RECIP3);
    q3     = MAG_W'(mag) * MAG_W'(fnmf_pkg::THIRD_OF_255)
             + MAG_W'(prod[PROD_W-1:fnmf_pkg::RECIP3_SHIFT]);
    case (sel_div)
      fnmf_pkg::DIV2: mag_q8 = MAG_W'(mag) << (fnmf_pkg::Q8_SHIFT - 1);
      fnmf_pkg::DIV3: mag_q8 = q3;
      fnmf_pkg::DIV4: mag_q8 = MAG_W'(mag) << (fnmf_pkg::Q8_SHIFT - 2);
      default:        mag_q8 = '0;
    endcase
    mean_full = neg ? (~mag_q8 + 1'b1) : mag_q8;
  end

  // handshake between the held word and the output register
  assign mask_left   = mask_q & ~sel_bit;
  assign pending     = |mask_q;
  assign load        = pending && (!tvalid_q || m_axis_tready);
  assign job_ready_o = !pending || (load && (mask_left == '0));
  assign accept_job  = job_valid_i && job_ready_o;

  always_comb begin
    mask_d = mask_q;
    if (accept_job) begin
      mask_d = job_i.mask;
    end else if (load) begin
      mask_d = mask_left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      tvalid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (load) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  // held word and output payload
  always_ff @(posedge clk_i) begin
    if (accept_job) begin
      job_q <= job_i;
    end
    if (load) begin
      tdata_q <= {PAD_W'(0), sel_col, sel_row, mean_full[fnmf_pkg::MEAN_W-1:0]};
      tlast_q <= sel_done;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;

  `FNMF_ASSERT_NXT(a_held_while_stalled, pending && !load, $stable(mask_q), "held results moved")
  `FNMF_ASSERT_NXT(a_load_presents, load, m_axis_tvalid, "loaded result not presented")

endmodule

/* sv/four_neighbour_mean_filter_top.sv */
// Four-neighbour mean filter: takes a frame of signed 16-bit samples in raster
// order on the s_axis side and gives, for each position, the mean of its up,
// down, left and right neighbours in signed Q.8, rounded to nearest (corners
// average two, edges three, interior four). The sample at (r,c) releases the
// result for (r-1,c); on the last row it also releases (r,c-1), and the final
// sample also releases its own corner, marked by tlast. Each result carries its
// row and column. One sample is taken per clock while s_axis_tready is high.
// The single output register drains one result per cycle while m_axis_tready is
// high, so on the last row s_axis_tready drops for one cycle after each sample
// past the first column (after the final one, until its corner result is
// loaded) while the extra results leave. The previous two rows come from two
// delay lines of MAX_WIDTH-entry RAMs; they need no clearing pass after reset.
// Writing frame_width or frame_height restarts the frame at row 0, column 0.
`include "four_neighbour_mean_filter_top_assert.svh"

module four_neighbour_mean_filter_top #(
  parameter int unsigned MAX_WIDTH  = fnmf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = fnmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fnmf_pkg::PADDR_W-1:0]       paddr,
  input  logic [fnmf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fnmf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] sample
  input  logic [fnmf_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [23:0] neighbour_mean, [33:24] out_row, [43:34] out_col, [47:44] zero
  output logic [fnmf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // frame_done
  output logic                               m_axis_tlast
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SUM_W = fnmf_pkg::SUM_W;

  logic [CW-1:0]                          w_last;
  logic [CW-1:0]                          ptr_last;
  logic [RW-1:0]                          h_last;
  logic                                   restart;
  logic                                   accept;
  logic                                   job_ready;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   sample;
  logic [CW-1:0]                          col_q, col_d;
  logic [RW-1:0]                          row_q, row_d;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   line_next;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   line_two;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   line_cur_q;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   line_prev_q;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   prev_q;
  logic signed [fnmf_pkg::SAMPLE_W-1:0]   prev2_q;
  logic                                   c_first, c_last, c_ge2;
  logic                                   r_first, r_last, r_ge2;
  logic [1:0]                             up_terms;
  logic signed [SUM_W-1:0]                up_left, up_right, up_top, left_left;
  fnmf_pkg::job_t                         job;

  assign sample        = s_axis_tdata;
  assign accept        = s_axis_tvalid && job_ready;
  assign s_axis_tready = job_ready;

  fnmf_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .w_last_o   (w_last),
    .ptr_last_o (ptr_last),
    .h_last_o   (h_last),
    .restart_o  (restart)
  );

  // sample from one row back, one column ahead
  fnmf_delay #(
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .push_i    (accept),
    .last_i    (ptr_last),
    .din_i     (sample),
    .dout_o    (line_next)
  );

  // sample from two rows back, same column
  fnmf_delay #(
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .push_i    (accept),
    .last_i    (ptr_last),
    .din_i     (line_prev_q),
    .dout_o    (line_two)
  );

  // position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (c_last) begin
        col_d = '0;
        row_d = r_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // window taps along the row above and the current row
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_cur_q  <= line_next;
      line_prev_q <= line_cur_q;
      prev_q      <= sample;
      prev2_q     <= prev_q;
    end
  end

  assign c_first = (col_q == '0);
  assign c_last  = (col_q == w_last);
  assign c_ge2   = (col_q > CW'(1));
  assign r_first = (row_q == '0);
  assign r_last  = (row_q == h_last);
  assign r_ge2   = (row_q > RW'(1));

  // neighbour sums and divisors for the results this word releases
  always_comb begin
    up_left   = c_first ? '0 : SUM_W'(line_prev_q);
    up_right  = c_last  ? '0 : SUM_W'(line_next);
    up_top    = r_ge2   ? SUM_W'(line_two) : '0;
    left_left = c_ge2   ? SUM_W'(prev2_q) : '0;
    up_terms  = 2'(!c_first) + 2'(!c_last) + 2'(r_ge2);

    job.mask[fnmf_pkg::RES_UP]     = !r_first;
    job.mask[fnmf_pkg::RES_LEFT]   = r_last && !c_first;
    job.mask[fnmf_pkg::RES_CORNER] = r_last && c_last;

    job.sum_up = SUM_W'(sample) + up_left + up_right + up_top;
    case (up_terms)
      2'd3:    job.div_up = fnmf_pkg::DIV4;
      2'd2:    job.div_up = fnmf_pkg::DIV3;
      default: job.div_up = fnmf_pkg::DIV2;
    endcase

    job.sum_left   = SUM_W'(sample) + SUM_W'(line_prev_q) + left_left;
    job.div_left   = c_ge2 ? fnmf_pkg::DIV3 : fnmf_pkg::DIV2;
    job.sum_corner = SUM_W'(prev_q) + SUM_W'(line_cur_q);

    job.row_cur  = fnmf_pkg::OUT_ROW_W'(row_q);
    job.row_up   = fnmf_pkg::OUT_ROW_W'(row_q) - 1'b1;
    job.col_cur  = fnmf_pkg::OUT_COL_W'(col_q);
    job.col_left = fnmf_pkg::OUT_COL_W'(col_q) - 1'b1;
  end

  fnmf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (accept),
    .job_i         (job),
    .job_ready_o   (job_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `FNMF_ASSERT_IMP(a_pos_in_frame, 1'b1, (col_q <= w_last) && (row_q <= h_last), "out of frame")
  `FNMF_ASSERT_NXT(a_frame_wrap, accept && r_last && c_last, ~|{col_q, row_q}, "no frame wrap")

endmodule
